FILE: rtl/lbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_pkg: shared types and constants of the LSB-first bit packer
// Field widths, operation codes, controller state and control/status groups.
// ---------------------------------------------------------------------------
package lbp_pkg;

  localparam int CODE_W            = 56;
  localparam int LEN_W             = 6;
  localparam int BYTE_W            = 8;
  localparam int MAX_CODE_BITS_DEF = 56;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take the accepted item into the accumulator
    logic shift;  // drop the byte just transferred
  } lbp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_byte;   // a complete byte is held
    logic last_byte;  // the held byte is the final one of this item
  } lbp_status_t;

endpackage
`default_nettype wire

FILE: rtl/lbp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_in_if: input channel of the bit packer
// Valid/ready handshake carrying operation, code and code length.
// ---------------------------------------------------------------------------
interface lbp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [lbp_pkg::CODE_W-1:0] code;
  logic [lbp_pkg::LEN_W-1:0]  code_length;

  modport source (output valid, output operation, output code, output code_length,
                  input ready);
  modport sink (input valid, input operation, input code, input code_length,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/lbp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_out_if: output channel of the bit packer
// Valid/ready handshake carrying one byte and its last flag.
// ---------------------------------------------------------------------------
interface lbp_out_if;
  logic                       valid;
  logic                       ready;
  logic [lbp_pkg::BYTE_W-1:0] out_byte;
  logic                       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/lbp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_datapath: accumulator and bit count of the bit packer
// Merges masked codes above the held bits and shifts out one byte per step.
// ---------------------------------------------------------------------------
module lbp_datapath #(
  parameter int MAX_CODE_BITS = lbp_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire lbp_pkg::lbp_cmd_t          cmd,
  output lbp_pkg::lbp_status_t            status,
  input  wire logic                       operation,
  input  wire logic [lbp_pkg::CODE_W-1:0] code,
  input  wire logic [lbp_pkg::LEN_W-1:0]  code_length,
  output logic [lbp_pkg::BYTE_W-1:0]      out_byte
);
  import lbp_pkg::*;

  localparam int ACC_W = MAX_CODE_BITS + BYTE_W - 1;
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         acc_next;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  logic [LEN_W-1:0]         len_sat;
  logic [MAX_CODE_BITS-1:0] code_m;
  logic [ACC_W-1:0]         code_sh;

  // saturate the length, then keep only the code bits below it
  always_comb begin
    if (code_length > LEN_W'(MAX_CODE_BITS)) begin
      len_sat = LEN_W'(MAX_CODE_BITS);
    end else begin
      len_sat = code_length;
    end
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      code_m[i] = code[i] & (LEN_W'(i) < len_sat);
    end
    code_sh = ACC_W'(code_m) << cnt[2:0];
  end

  always_comb begin
    acc_next = acc;
    cnt_next = cnt;
    if (cmd.load) begin
      if (op_t'(operation) == OP_FLUSH) begin
        // a held partial byte leaves as one zero-padded byte
        if (cnt != '0) begin
          cnt_next = CNT_W'(BYTE_W);
        end else begin
          acc_next = '0;
        end
      end else begin
        acc_next = acc | code_sh;
        cnt_next = CNT_W'(cnt[2:0]) + CNT_W'(len_sat);
      end
    end else if (cmd.shift) begin
      acc_next = acc >> BYTE_W;
      cnt_next = cnt - CNT_W'(BYTE_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  assign out_byte         = acc[BYTE_W-1:0];
  assign status.has_byte  = (cnt >= CNT_W'(BYTE_W));
  assign status.last_byte = (cnt < CNT_W'(2 * BYTE_W));

endmodule
`default_nettype wire

FILE: rtl/lbp_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_controller: sequencing state machine of the bit packer
// Takes one item, then drains its bytes one transfer at a time.
// ---------------------------------------------------------------------------
module lbp_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire lbp_pkg::lbp_status_t status,
  output lbp_pkg::lbp_cmd_t         cmd
);
  import lbp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.has_byte) begin
          state_next = ST_IDLE;
        end else if (out_ready && status.last_byte) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.shift = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EMIT: begin
        out_valid = status.has_byte;
        cmd.shift = status.has_byte & out_ready;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/lsb_first_bit_packer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lsb_first_bit_packer_core: variable-length code packer, LSB first
// Appends codes of up to MAX_CODE_BITS bits and emits completed bytes.
// ---------------------------------------------------------------------------
// The first byte of a write or flush is offered the cycle after accept.
// A new item is taken only after the previous one has drained, and the output is
//   paced by the byte shifter that drops one byte per transfer.
// A write emits at most 7 bytes, a flush at most 1; the final byte carries last.
// Reset (rst, synchronous): accumulator and bit count clear, controller idles.
module lsb_first_bit_packer_core #(
  parameter int MAX_CODE_BITS = lbp_pkg::MAX_CODE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  lbp_in_if.sink   in_ch,
  lbp_out_if.source out_ch
);
  import lbp_pkg::*;

  lbp_cmd_t    cmd;
  lbp_status_t status;

  // Controller: accept in idle, then hold in emit until the last transfer.
  lbp_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: the accumulator low byte is the registered output byte.
  lbp_datapath #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .operation   (in_ch.operation),
    .code        (in_ch.code),
    .code_length (in_ch.code_length),
    .out_byte    (out_ch.out_byte)
  );

  assign out_ch.last = status.last_byte;

  // No input is taken while a byte is still offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while output byte pending");

  // A transfer marked last ends the item's output.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> !out_ch.valid)
    else $error("byte offered after last transfer");

  // An accepted item is worked before another is taken.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item taken in back-to-back cycle");

endmodule
`default_nettype wire

FILE: tb/tb_lsb_first_bit_packer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lsb_first_bit_packer_core: self-checking bench for the LSB-first packer
// Feeds directed and random write/flush items with random idle gaps on both
// channels. A bit-level model of the accumulator predicts every output byte
// and its last flag, and each byte is compared in order as it is transferred.
// ---------------------------------------------------------------------------
module tb_lsb_first_bit_packer_core;
  import lbp_pkg::*;

  localparam int RANDOM_ITEMS  = 375;
  localparam int LONG_HOLD     = 300;  // sink hold-off, in cycles
  localparam int HOLD_AT_BYTES = 100;  // start the hold-off after this many bytes
  localparam int DRAIN_AT_ITEM = 200;  // pause the source before this random item
  localparam int TAIL_CYCLES   = 20;   // settle time after the last byte

  typedef struct {
    op_t                 op;
    logic [CODE_W-1:0]   code;
    logic [LEN_W-1:0]    len;
    bit                  drain;  // hold this item until all bytes are out
  } code_item_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbp_in_if  in_ch ();
  lbp_out_if out_ch ();

  lsb_first_bit_packer_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Items waiting to be offered, and bytes the packer still owes us.
  code_item_t   pending_items[$];
  packed_byte_t expected_bytes[$];

  // Shadow state of the packer: pending bits, oldest at bit 0.
  logic [62:0] shadow_bits;
  logic [2:0]  shadow_count;

  int errors          = 0;
  int items_accepted  = 0;
  int flushes_seen    = 0;
  int bytes_checked   = 0;
  int gap_left        = 0;
  int stall_left      = 0;
  int hold_left       = 0;
  bit long_hold_done  = 1'b0;
  bit drain_done      = 1'b0;

  // Work out the bytes that one accepted item releases and queue them.
  task automatic predict_packed_bytes(input op_t op, input logic [CODE_W-1:0] code,
                                      input logic [LEN_W-1:0] len);
    int                eff_len;
    int                total;
    int                nbytes;
    logic [CODE_W-1:0] kept;
    packed_byte_t      pb;
    if (op == OP_FLUSH) begin
      // Emit the partial byte zero-padded, then start clean.
      if (shadow_count != 0) begin
        pb.data = shadow_bits[7:0];
        pb.last = 1'b1;
        expected_bytes.push_back(pb);
      end
      shadow_bits  = '0;
      shadow_count = '0;
      return;
    end
    // Saturate oversize lengths, then drop code bits above the length.
    eff_len = (len > MAX_CODE_BITS_DEF) ? MAX_CODE_BITS_DEF : int'(len);
    kept    = code & ((56'h1 << eff_len) - 56'h1);
    shadow_bits = shadow_bits | (63'(kept) << shadow_count);
    total  = int'(shadow_count) + eff_len;
    nbytes = total / 8;
    for (int i = 0; i < nbytes; i++) begin
      pb.data = shadow_bits[7:0];
      pb.last = (i == nbytes - 1);
      expected_bytes.push_back(pb);
      shadow_bits = shadow_bits >> 8;
    end
    shadow_count = 3'(total % 8);
  endtask

  task automatic queue_item(input op_t op, input logic [CODE_W-1:0] code,
                            input logic [LEN_W-1:0] len);
    code_item_t it;
    it.op    = op;
    it.code  = code;
    it.len   = len;
    it.drain = 1'b0;
    pending_items.push_back(it);
  endtask

  // Drive every input to a known value before the first edge.
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_WRITE;
    in_ch.code        = '0;
    in_ch.code_length = '0;
    out_ch.ready      = 1'b0;
    shadow_bits       = '0;
    shadow_count      = '0;
  end

  // -------------------------------------------------------------------------
  // Source side. On a transfer, advance the model; then either hold the
  // current item, idle for the drawn gap, or present the next queued item.
  // Gaps alternate between random stretches and back-to-back stretches.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    code_item_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_packed_bytes(op_t'(in_ch.operation), in_ch.code, in_ch.code_length);
        items_accepted++;
        if (in_ch.operation == OP_FLUSH) flushes_seen++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && expected_bytes.size() > 0)) begin
          nxt = pending_items.pop_front();
          if (nxt.drain) drain_done = 1'b1;
          in_ch.valid       <= 1'b1;
          in_ch.operation   <= nxt.op;
          in_ch.code        <= nxt.code;
          in_ch.code_length <= nxt.len;
          gap_left = ((items_accepted >> 6) & 1) ? 0 : $urandom_range(0, 15);
        end else begin
          // Idle: nothing left, or waiting for the packer to drain.
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sink side. Check each transferred byte against the oldest prediction,
  // then draw a stall before the next one. Once, hold off for a long
  // stretch so the packer backs up and stalls its input.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none, actual byte %02h last %0b",
                   $time, out_ch.out_byte, out_ch.last);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.out_byte !== want.data) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.data, out_ch.out_byte);
            errors++;
          end
          if (out_ch.last !== want.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want.last, out_ch.last);
            errors++;
          end
          bytes_checked++;
        end
        stall_left = ((bytes_checked >> 7) & 1) ? 0 : $urandom_range(0, 15);
      end
      if (!long_hold_done && bytes_checked >= HOLD_AT_BYTES) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run.
  // -------------------------------------------------------------------------
  initial begin
    int                sel;
    logic [CODE_W-1:0] rcode;
    logic [LEN_W-1:0]  rlen;
    code_item_t        it;

    // Directed: flush on empty, zero length, full and saturated lengths,
    // garbage above the length, exact byte boundaries, flush padding.
    queue_item(OP_FLUSH, '1, 6'd0);                   // nothing held yet
    queue_item(OP_WRITE, '1, 6'd0);                   // zero-length write
    queue_item(OP_WRITE, '1, 6'd56);                  // seven full bytes
    queue_item(OP_WRITE, 56'hFFFF_FFFF_FFFF_A5, 6'd8); // upper bits dropped
    queue_item(OP_WRITE, 56'hFF_FFFF_FFFF_FFFD, 6'd3);
    queue_item(OP_WRITE, 56'h12_3456_789A_BCDE, 6'd63); // saturates to max
    queue_item(OP_WRITE, '0, 6'd0);                   // no byte with bits held
    queue_item(OP_FLUSH, '0, 6'd0);                   // padded partial byte
    queue_item(OP_FLUSH, '0, 6'd0);                   // empty again
    queue_item(OP_WRITE, 56'h7F, 6'd7);
    queue_item(OP_WRITE, '1, 6'd57);                  // 63 bits pending
    queue_item(OP_WRITE, 56'h1, 6'd1);
    queue_item(OP_WRITE, 56'h15, 6'd5);
    queue_item(OP_FLUSH, '1, 6'd63);
    queue_item(OP_WRITE, '0, 6'd56);
    queue_item(OP_WRITE, 56'hFF_FFFF_FFFF_FFFE, 6'd1);
    queue_item(OP_FLUSH, '0, 6'd0);                   // flush a lone zero bit
    queue_item(OP_WRITE, 56'hA, 6'd4);
    queue_item(OP_WRITE, 56'h5, 6'd4);
    queue_item(OP_WRITE, 56'hAA_5555_AAAA_5555, 6'd40);
    queue_item(OP_WRITE, 56'h3, 6'd2);
    queue_item(OP_FLUSH, '0, 6'd0);

    // Random: mostly short codes as an entropy coder would send, some long
    // and oversize ones, zero lengths and flushes mixed in.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel   = $urandom_range(0, 99);
      rcode = CODE_W'({$urandom, $urandom});
      if (sel < 10) begin
        it.op = OP_FLUSH;
        rlen  = 6'($urandom);
      end else begin
        it.op = OP_WRITE;
        if (sel < 15)      rlen = '0;
        else if (sel < 70) rlen = 6'($urandom_range(1, 12));
        else if (sel < 90) rlen = 6'($urandom_range(13, 56));
        else               rlen = 6'($urandom_range(56, 63));
      end
      it.code  = rcode;
      it.len   = rlen;
      it.drain = (i == DRAIN_AT_ITEM);
      pending_items.push_back(it);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken, then for every byte to come out.
    while (pending_items.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d items accepted (%0d flushes), %0d bytes checked, %0d errors",
             items_accepted, flushes_seen, bytes_checked, errors);
    $display("run: long sink hold-off %0s, source drain pause %0s",
             long_hold_done ? "done" : "missed", drain_done ? "done" : "missed");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d bytes still expected", $time, expected_bytes.size());
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
rtl/lbp_pkg.sv
rtl/lbp_in_if.sv
rtl/lbp_out_if.sv
rtl/lbp_datapath.sv
rtl/lbp_controller.sv
rtl/lsb_first_bit_packer_core.sv
tb/tb_lsb_first_bit_packer_core.sv
